>>> rtl/core/tgp_pkg.sv
// Package for the turtle grid plotter: codes, widths, types and the FSM state.
// No dependencies; every module of the plotter imports it.

package tgp_pkg;

    // Fixed field widths.
    localparam int ROW_W   = 32;
    localparam int COORD_W = 5;
    localparam int STEPS_W = 6;
    localparam int OP_W    = 3;
    localparam int HEAD_W  = 2;
    localparam int MAX_ROWS = 32;

    // Default grid size handed to the top level.
    localparam int GRID_DEFAULT = 32;

    // Stream data widths, padded to whole bytes.
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 56;

    // Command codes.
    localparam logic [OP_W-1:0] OP_PEN_UP    = 3'd0;
    localparam logic [OP_W-1:0] OP_PEN_DOWN  = 3'd1;
    localparam logic [OP_W-1:0] OP_TURN_R    = 3'd2;
    localparam logic [OP_W-1:0] OP_TURN_L    = 3'd3;
    localparam logic [OP_W-1:0] OP_MOVE      = 3'd4;
    localparam logic [OP_W-1:0] OP_PRINT     = 3'd5;

    // Heading codes.
    localparam logic [HEAD_W-1:0] HEAD_RIGHT = 2'd0;
    localparam logic [HEAD_W-1:0] HEAD_DOWN  = 2'd1;
    localparam logic [HEAD_W-1:0] HEAD_LEFT  = 2'd2;
    localparam logic [HEAD_W-1:0] HEAD_UP    = 2'd3;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_WRITE,
        ST_PREAD,
        ST_PEMIT,
        ST_STAT
    } t_state;

    // Request from the sequencer to the grid memory.
    typedef struct packed {
        logic               we;
        logic [COORD_W-1:0] waddr;
        logic [ROW_W-1:0]   wdata;
        logic               re;
        logic [COORD_W-1:0] raddr;
    } t_mem_req;

    // Result of the shared step unit.
    typedef struct packed {
        logic [COORD_W-1:0] nx;
        logic [COORD_W-1:0] ny;
        logic               stop;
    } t_step;

endpackage : tgp_pkg

>>> rtl/core/tgp_grid_mem.sv
// Grid row memory with one write and one registered read port.
// Per-row valid bits make unwritten rows read as zero after reset. Uses tgp_pkg.

module tgp_grid_mem #(
    parameter int DEPTH = tgp_pkg::MAX_ROWS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tgp_pkg::t_mem_req i_req,
    output logic [tgp_pkg::ROW_W-1:0] o_rdata
);
    import tgp_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [ROW_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [ROW_W-1:0] r_rdata;

    // Row storage, no reset.
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr[AW-1:0]] <= i_req.wdata;
        end
    end

    // Valid bits, cleared at reset so the board reads as blank.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_req.we) begin
            r_valid[i_req.waddr[AW-1:0]] <= 1'b1;
        end
    end

    // Registered read; holds its value between reads.
    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            if (r_valid[i_req.raddr[AW-1:0]]) begin
                r_rdata <= r_mem[i_req.raddr[AW-1:0]];
            end else begin
                r_rdata <= '0;
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule : tgp_grid_mem

>>> rtl/core/tgp_step_unit.sv
// Shared step unit: next cell along the heading and the stop decision.
// Used once per written cell by the sequencer. Uses tgp_pkg.

module tgp_step_unit #(
    parameter int SIZE = tgp_pkg::MAX_ROWS
) (
    input  logic [tgp_pkg::COORD_W-1:0] i_x,
    input  logic [tgp_pkg::COORD_W-1:0] i_y,
    input  logic [tgp_pkg::HEAD_W-1:0]  i_head,
    input  logic [tgp_pkg::STEPS_W-1:0] i_rem,
    output tgp_pkg::t_step              o_step
);
    import tgp_pkg::*;

    localparam logic [COORD_W-1:0] LAST = COORD_W'(SIZE - 1);

    logic at_edge;

    // Edge test and neighbor cell for the current heading.
    always_comb begin
        o_step.nx = i_x;
        o_step.ny = i_y;
        at_edge   = 1'b0;
        case (i_head)
            HEAD_RIGHT: begin
                at_edge   = (i_x == LAST);
                o_step.nx = i_x + COORD_W'(1);
            end
            HEAD_DOWN: begin
                at_edge   = (i_y == LAST);
                o_step.ny = i_y + COORD_W'(1);
            end
            HEAD_LEFT: begin
                at_edge   = (i_x == '0);
                o_step.nx = i_x - COORD_W'(1);
            end
            HEAD_UP: begin
                at_edge   = (i_y == '0);
                o_step.ny = i_y - COORD_W'(1);
            end
            default: begin
                at_edge = 1'b1;
            end
        endcase
        // Stop after this cell if it was the last one asked for or the edge.
        o_step.stop = at_edge || (i_rem == STEPS_W'(1));
    end

endmodule : tgp_step_unit

>>> rtl/core/turtle_grid_plotter.sv
// Turtle grid plotter top level: command sequencer, turtle state, output register.
// Depends on tgp_pkg, tgp_grid_mem and tgp_step_unit.
// Commands run one at a time: a move does one row read-modify-write per written cell,
// print reads and emits every row in turn, and each command ends with its result
// transaction; a stalled result stream holds the sequencer and the command stream.
// Synchronous reset clears the turtle state and marks every grid row blank at once.

module turtle_grid_plotter #(
    parameter int GRID = tgp_pkg::GRID_DEFAULT
) (
    input  logic i_clk,
    input  logic i_rst_n,
    // Command stream.
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // Fields from bit 0: op[2:0], steps[8:3], zero pad.
    input  logic [tgp_pkg::S_DATA_W-1:0]   i_s_axis_tdata,
    // Result stream.
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // Fields from bit 0: row_bits[31:0], row_index[36:32], pos_x_out[41:37],
    // pos_y_out[46:42], heading_out[48:47], zero pad.
    output logic [tgp_pkg::M_DATA_W-1:0]   o_m_axis_tdata,
    output logic                           o_m_axis_tlast
);
    import tgp_pkg::*;

    localparam int SIZE = (GRID < 2) ? 2 : ((GRID > MAX_ROWS) ? MAX_ROWS : GRID);
    localparam logic [COORD_W-1:0] LAST_ROW = COORD_W'(SIZE - 1);

    t_state r_state, n_state;

    logic               r_pen, n_pen;
    logic [HEAD_W-1:0]  r_head, n_head;
    logic [COORD_W-1:0] r_x, n_x;
    logic [COORD_W-1:0] r_y, n_y;
    logic [STEPS_W-1:0] r_rem, n_rem;
    logic [COORD_W-1:0] r_row, n_row;

    logic               r_m_valid;
    logic [ROW_W-1:0]   r_m_row_bits;
    logic [COORD_W-1:0] r_m_row_index;
    logic [COORD_W-1:0] r_m_pos_x;
    logic [COORD_W-1:0] r_m_pos_y;
    logic [HEAD_W-1:0]  r_m_head;
    logic               r_m_last;

    logic [OP_W-1:0]    in_op;
    logic [STEPS_W-1:0] in_steps;
    logic               in_acc;
    logic               out_free;
    logic               load_row;
    logic               load_stat;
    logic [ROW_W-1:0]   rdata;
    logic [ROW_W-1:0]   cell_bit;
    t_mem_req           mem_req;
    t_step              step;

    assign in_op    = i_s_axis_tdata[OP_W-1:0];
    assign in_steps = i_s_axis_tdata[OP_W+STEPS_W-1:OP_W];
    assign in_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free = !r_m_valid || i_m_axis_tready;
    assign cell_bit = ROW_W'(1) << r_x;

    tgp_grid_mem #(
        .DEPTH (SIZE)
    ) u_grid_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mem_req),
        .o_rdata (rdata)
    );

    tgp_step_unit #(
        .SIZE (SIZE)
    ) u_step_unit (
        .i_x    (r_x),
        .i_y    (r_y),
        .i_head (r_head),
        .i_rem  (r_rem),
        .o_step (step)
    );

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (in_op == OP_MOVE && in_steps != '0) begin
                        n_state = ST_READ;
                    end else if (in_op == OP_PRINT) begin
                        n_state = ST_PREAD;
                    end else begin
                        n_state = ST_STAT;
                    end
                end
            end
            ST_READ:  n_state = ST_WRITE;
            ST_WRITE: n_state = step.stop ? ST_STAT : ST_READ;
            ST_PREAD: n_state = ST_PEMIT;
            ST_PEMIT: begin
                if (out_free) begin
                    n_state = (r_row == LAST_ROW) ? ST_IDLE : ST_PREAD;
                end
            end
            ST_STAT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs: memory requests, output loads and ready.
    always_comb begin
        mem_req         = '0;
        load_row        = 1'b0;
        load_stat       = 1'b0;
        o_s_axis_tready = 1'b0;
        case (r_state)
            ST_IDLE:  o_s_axis_tready = 1'b1;
            ST_READ: begin
                mem_req.re    = 1'b1;
                mem_req.raddr = r_y;
            end
            ST_WRITE: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = r_y;
                mem_req.wdata = r_pen ? (rdata | cell_bit) : (rdata & ~cell_bit);
            end
            ST_PREAD: begin
                mem_req.re    = 1'b1;
                mem_req.raddr = r_row;
            end
            ST_PEMIT: load_row  = out_free;
            ST_STAT:  load_stat = out_free;
            default: ;
        endcase
    end

    // Turtle state and counters.
    always_comb begin
        n_pen  = r_pen;
        n_head = r_head;
        n_x    = r_x;
        n_y    = r_y;
        n_rem  = r_rem;
        n_row  = r_row;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_rem = in_steps;
                    n_row = '0;
                    case (in_op)
                        OP_PEN_UP:   n_pen  = 1'b0;
                        OP_PEN_DOWN: n_pen  = 1'b1;
                        OP_TURN_R:   n_head = r_head + HEAD_W'(1);
                        OP_TURN_L:   n_head = r_head - HEAD_W'(1);
                        default: ;
                    endcase
                end
            end
            ST_WRITE: begin
                if (!step.stop) begin
                    n_x   = step.nx;
                    n_y   = step.ny;
                    n_rem = r_rem - STEPS_W'(1);
                end
            end
            ST_PEMIT: begin
                if (out_free && r_row != LAST_ROW) begin
                    n_row = r_row + COORD_W'(1);
                end
            end
            default: ;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_pen     <= 1'b0;
            r_head    <= HEAD_RIGHT;
            r_x       <= '0;
            r_y       <= '0;
            r_rem     <= '0;
            r_row     <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pen   <= n_pen;
            r_head  <= n_head;
            r_x     <= n_x;
            r_y     <= n_y;
            r_rem   <= n_rem;
            r_row   <= n_row;
            if (load_row || load_stat) begin
                r_m_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // Output payload register.
    always_ff @(posedge i_clk) begin
        if (load_row || load_stat) begin
            r_m_row_bits  <= load_row ? rdata : '0;
            r_m_row_index <= load_row ? r_row : '0;
            r_m_pos_x     <= r_x;
            r_m_pos_y     <= r_y;
            r_m_head      <= r_head;
            r_m_last      <= load_stat || (r_row == LAST_ROW);
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tlast  = r_m_last;
    assign o_m_axis_tdata  = {7'd0, r_m_head, r_m_pos_y, r_m_pos_x,
                              r_m_row_index, r_m_row_bits};

endmodule : turtle_grid_plotter

>>> bench/turtle_grid_plotter_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for turtle_grid_plotter: a directed command table, then random commands.
// Each result row is checked against a grid and turtle tracker or a typed-in table outcome.
// Depends on tgp_pkg and the plotter RTL.

module turtle_grid_plotter_tb;
    import tgp_pkg::*;

    localparam int GRID_SIZE = GRID_DEFAULT;
    localparam int SIDE = (GRID_SIZE < 2) ? 2 : ((GRID_SIZE > MAX_ROWS) ? MAX_ROWS : GRID_SIZE);

    // Opcodes that the plotter has no command for.
    localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

    localparam int RANDOM_CMDS  = 200;
    localparam int DRAIN_CYCLES = 4 * SIDE + 16;
    localparam int MAX_SHOWN    = 10;

    // One result transaction, split into its fields.
    typedef struct packed {
        logic [ROW_W-1:0]   row_bits;
        logic [COORD_W-1:0] row_index;
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
        logic [HEAD_W-1:0]  heading;
        logic               last;
    } t_plot_result;

    // One command of the directed table; fixed is set where the outcome is typed in.
    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [STEPS_W-1:0] steps;
        bit                 fixed;
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
        logic [HEAD_W-1:0]  heading;
    } t_cmd_row;

    logic                i_clk;
    logic                i_rst_n;
    logic                s_valid;
    logic                s_ready;
    logic [S_DATA_W-1:0] s_data;
    logic                m_valid;
    logic                m_ready;
    logic [M_DATA_W-1:0] m_data;
    logic                m_last;

    // Tracked plotter state.
    logic [ROW_W-1:0]   board [0:MAX_ROWS-1];
    logic [COORD_W-1:0] turtle_x;
    logic [COORD_W-1:0] turtle_y;
    logic [HEAD_W-1:0]  turtle_head;
    logic               pen_down;

    t_plot_result pending_rows[$];
    t_cmd_row     cmd_table[$];
    int           mismatches = 0;
    int           burst_left = 0;

    turtle_grid_plotter #(
        .GRID(GRID_SIZE)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tlast  (m_last)
    );

    // 10 ns clock.
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Apply one command to the tracked state; keep selects whether its rows are queued.
    task automatic plot_command(input logic [OP_W-1:0] op, input logic [STEPS_W-1:0] steps,
                                input bit keep);
        int room;
        int cnt;
        int cx;
        int cy;
        t_plot_result res;
        case (op)
            OP_PEN_UP:   pen_down = 1'b0;
            OP_PEN_DOWN: pen_down = 1'b1;
            OP_TURN_R:   turtle_head = turtle_head + HEAD_W'(1);
            OP_TURN_L:   turtle_head = turtle_head - HEAD_W'(1);
            OP_MOVE: begin
                if (steps != 0) begin
                    cx = turtle_x;
                    cy = turtle_y;
                    case (turtle_head)
                        HEAD_RIGHT: room = SIDE - cx;
                        HEAD_DOWN:  room = SIDE - cy;
                        HEAD_LEFT:  room = cx + 1;
                        default:    room = cy + 1;
                    endcase
                    cnt = (int'(steps) < room) ? int'(steps) : room;
                    for (int i = 0; i < cnt; i++) begin
                        board[cy][cx] = pen_down;
                        turtle_x = cx[COORD_W-1:0];
                        turtle_y = cy[COORD_W-1:0];
                        case (turtle_head)
                            HEAD_RIGHT: cx++;
                            HEAD_DOWN:  cy++;
                            HEAD_LEFT:  cx--;
                            default:    cy--;
                        endcase
                    end
                end
            end
            OP_PRINT: begin
                // Print returns every row, with the turtle state on each.
                for (int r = 0; r < SIDE; r++) begin
                    res.row_bits  = board[r];
                    res.row_index = r[COORD_W-1:0];
                    res.pos_x     = turtle_x;
                    res.pos_y     = turtle_y;
                    res.heading   = turtle_head;
                    res.last      = (r == SIDE - 1);
                    if (keep) pending_rows.push_back(res);
                end
                return;
            end
            default: ;
        endcase
        res           = '0;
        res.pos_x     = turtle_x;
        res.pos_y     = turtle_y;
        res.heading   = turtle_head;
        res.last      = 1'b1;
        if (keep) pending_rows.push_back(res);
    endtask

    // Queue the outcome typed into a table row: a blank board for print, one status otherwise.
    task automatic queue_fixed(input t_cmd_row row);
        t_plot_result res;
        res         = '0;
        res.pos_x   = row.pos_x;
        res.pos_y   = row.pos_y;
        res.heading = row.heading;
        if (row.op == OP_PRINT) begin
            for (int r = 0; r < SIDE; r++) begin
                res.row_index = r[COORD_W-1:0];
                res.last      = (r == SIDE - 1);
                pending_rows.push_back(res);
            end
        end else begin
            res.last = 1'b1;
            pending_rows.push_back(res);
        end
    endtask

    task automatic add_row(input logic [OP_W-1:0] op, input logic [STEPS_W-1:0] steps,
                           input bit fixed, input int x, input int y,
                           input logic [HEAD_W-1:0] head);
        t_cmd_row row;
        row.op      = op;
        row.steps   = steps;
        row.fixed   = fixed;
        row.pos_x   = x[COORD_W-1:0];
        row.pos_y   = y[COORD_W-1:0];
        row.heading = head;
        cmd_table.push_back(row);
    endtask

    // Drive one command transaction in bursts with random gaps, then track it.
    task automatic send_command(input t_cmd_row row);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 12);
            repeat (gap) begin
                @(negedge i_clk);
                s_valid <= 1'b0;
            end
        end
        burst_left--;
        @(negedge i_clk);
        s_valid <= 1'b1;
        s_data  <= S_DATA_W'({row.steps, row.op});
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
        plot_command(row.op, row.steps, !row.fixed);
        if (row.fixed) queue_fixed(row);
    endtask

    // Random command, weighted toward moves so the turtle roams the board.
    function automatic t_cmd_row random_command();
        t_cmd_row row;
        int pick;
        row       = '0;
        pick      = $urandom_range(0, 99);
        row.steps = STEPS_W'($urandom_range(0, 63));
        if (pick < 8)       row.op = OP_PEN_UP;
        else if (pick < 18) row.op = OP_PEN_DOWN;
        else if (pick < 32) row.op = OP_TURN_R;
        else if (pick < 46) row.op = OP_TURN_L;
        else if (pick < 87) begin
            row.op = OP_MOVE;
            pick   = $urandom_range(0, 9);
            if (pick < 5)      row.steps = STEPS_W'($urandom_range(0, 7));
            else if (pick < 8) row.steps = STEPS_W'($urandom_range(0, 63));
            else               row.steps = STEPS_W'($urandom_range(32, 63));
        end
        else if (pick < 93) row.op = OP_PRINT;
        else                row.op = $urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7;
        return row;
    endfunction

    // Stimulus and end of run.
    initial begin
        i_rst_n = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        for (int r = 0; r < MAX_ROWS; r++) board[r] = '0;
        turtle_x    = '0;
        turtle_y    = '0;
        turtle_head = HEAD_RIGHT;
        pen_down    = 1'b0;

        // Directed part: reset state, ignored fields, spare opcodes, a border at full reach.
        add_row(OP_PRINT,    6'd0,  1'b1, 0,  0,  HEAD_RIGHT);
        add_row(OP_PEN_UP,   6'd63, 1'b1, 0,  0,  HEAD_RIGHT);
        add_row(OP_MOVE,     6'd0,  1'b1, 0,  0,  HEAD_RIGHT);
        add_row(OP_SPARE_6,  6'd0,  1'b1, 0,  0,  HEAD_RIGHT);
        add_row(OP_SPARE_7,  6'd63, 1'b1, 0,  0,  HEAD_RIGHT);
        add_row(OP_PEN_DOWN, 6'd21, 1'b1, 0,  0,  HEAD_RIGHT);
        add_row(OP_MOVE,     6'd63, 1'b1, SIDE - 1, 0,  HEAD_RIGHT);
        add_row(OP_TURN_R,   6'd0,  1'b1, SIDE - 1, 0,  HEAD_DOWN);
        add_row(OP_MOVE,     6'd63, 1'b1, SIDE - 1, SIDE - 1, HEAD_DOWN);
        add_row(OP_TURN_R,   6'd42, 1'b1, SIDE - 1, SIDE - 1, HEAD_LEFT);
        add_row(OP_MOVE,     6'd63, 1'b1, 0,  SIDE - 1, HEAD_LEFT);
        add_row(OP_TURN_R,   6'd0,  1'b1, 0,  SIDE - 1, HEAD_UP);
        add_row(OP_MOVE,     6'd63, 1'b1, 0,  0,  HEAD_UP);
        add_row(OP_TURN_R,   6'd0,  1'b1, 0,  0,  HEAD_RIGHT);
        add_row(OP_TURN_L,   6'd0,  1'b1, 0,  0,  HEAD_UP);
        add_row(OP_MOVE,     6'd1,  1'b1, 0,  0,  HEAD_UP);
        add_row(OP_PRINT,    6'd0,  1'b0, 0,  0,  HEAD_RIGHT);
        add_row(OP_PEN_UP,   6'd0,  1'b0, 0,  0,  HEAD_RIGHT);
        add_row(OP_TURN_L,   6'd0,  1'b0, 0,  0,  HEAD_RIGHT);
        add_row(OP_MOVE,     6'd5,  1'b0, 0,  0,  HEAD_RIGHT);
        add_row(OP_TURN_L,   6'd0,  1'b0, 0,  0,  HEAD_RIGHT);
        add_row(OP_MOVE,     6'd10, 1'b0, 0,  0,  HEAD_RIGHT);
        add_row(OP_PRINT,    6'd63, 1'b0, 0,  0,  HEAD_RIGHT);

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (cmd_table[i]) send_command(cmd_table[i]);
        for (int n = 0; n < RANDOM_CMDS; n++) send_command(random_command());
        @(negedge i_clk);
        s_valid <= 1'b0;

        while (pending_rows.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Result backpressure: runs of always ready, random ready, or ready one cycle in four.
    initial begin
        int mode;
        int len;
        int phase;
        m_ready = 1'b0;
        phase   = 0;
        forever begin
            mode = $urandom_range(0, 2);
            len  = $urandom_range(10, 150);
            repeat (len) begin
                @(negedge i_clk);
                phase++;
                case (mode)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= 1'($urandom_range(0, 1));
                    default: m_ready <= (phase % 4 == 0);
                endcase
            end
        end
    end

    // Compare every accepted result transaction with the oldest queued row.
    always @(posedge i_clk) begin
        t_plot_result got;
        t_plot_result want;
        if (i_rst_n && m_valid && m_ready) begin
            got.row_bits  = m_data[31:0];
            got.row_index = m_data[36:32];
            got.pos_x     = m_data[41:37];
            got.pos_y     = m_data[46:42];
            got.heading   = m_data[48:47];
            got.last      = m_last;
            if (pending_rows.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("Unexpected result: row %h idx %0d x %0d y %0d head %0d last %b",
                             got.row_bits, got.row_index, got.pos_x, got.pos_y,
                             got.heading, got.last);
            end else begin
                want = pending_rows.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display({"Result differs: want row %h idx %0d x %0d y %0d ",
                                  "head %0d last %b, got row %h idx %0d x %0d y %0d ",
                                  "head %0d last %b"},
                                 want.row_bits, want.row_index, want.pos_x, want.pos_y,
                                 want.heading, want.last, got.row_bits, got.row_index,
                                 got.pos_x, got.pos_y, got.heading, got.last);
                end
            end
        end
    end

    // Hard stop in case the plotter hangs.
    initial begin
        #3000000;
        $display("Mismatches found");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/tgp_pkg.sv
rtl/core/tgp_grid_mem.sv
rtl/core/tgp_step_unit.sv
rtl/core/turtle_grid_plotter.sv
bench/turtle_grid_plotter_tb.sv
